// ===== rtl/core/tbta_pkg.sv =====
package tbta_pkg;

    localparam int ALARM_SLOTS_DEF = 3;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 40;
    localparam int CFG_W           = 16;

    localparam logic [CFG_W-1:0] GAP_TIMEOUT_RESET = 16'd500;

    localparam logic [7:0] ALARM_BASE = 8'd24;
    localparam logic [7:0] HOUR_MAX   = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;

    typedef enum logic [1:0] {
        FUNC_BYTE      = 2'd0,
        FUNC_ACK_TIME  = 2'd1,
        FUNC_ACK_ALARM = 2'd2,
        FUNC_NONE      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STG_IDLE = 2'd0,
        STG_ONE  = 2'd1,
        STG_TWO  = 2'd2
    } stage_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  rx_byte;
        logic [31:0] now_tick;
    } item_t;

    typedef struct packed {
        logic       enabled;
        logic [4:0] hour;
        logic [5:0] minute;
    } alarm_entry_t;

    typedef struct packed {
        logic       frame_done;
        logic [4:0] time_hour;
        logic [5:0] time_minute;
        logic [5:0] time_second;
        logic       time_valid;
        logic       time_new;
        logic       alarm_new;
        logic [1:0] alarm_slot;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic       alarm_enabled;
        logic       persist_request;
    } result_t;

endpackage

// ===== rtl/core/tbta_in_stage.sv =====
module tbta_in_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tbta_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                           s_tuser,
    input  logic                                 take,
    output logic                                 item_valid,
    output tbta_pkg::item_t                      item
);
    import tbta_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_fire;

    assign s_tready   = !valid_reg || take;
    assign s_fire     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.func     <= func_t'(s_tuser);
            item_reg.rx_byte  <= s_tdata[7:0];
            item_reg.now_tick <= s_tdata[39:8];
        end
    end

endmodule

// ===== rtl/core/tbta_core.sv =====
module tbta_core #(
    parameter int ALARM_SLOTS = tbta_pkg::ALARM_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr,
    input  logic [tbta_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          item_valid,
    input  tbta_pkg::item_t               item,
    output tbta_pkg::result_t             result
);
    import tbta_pkg::*;

    localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    logic [CFG_W-1:0]  timeout_reg;
    stage_t            stage_reg;
    stage_t            stage_next;
    stage_t            stage_eff;
    logic [7:0]        byte_one_reg;
    logic [7:0]        byte_one_next;
    logic [7:0]        byte_two_reg;
    logic [7:0]        byte_two_next;
    logic [31:0]       last_tick_reg;
    logic [31:0]       last_tick_next;
    logic [4:0]        hour_reg;
    logic [4:0]        hour_next;
    logic [5:0]        minute_reg;
    logic [5:0]        minute_next;
    logic [5:0]        second_reg;
    logic [5:0]        second_next;
    logic              clock_valid_reg;
    logic              clock_valid_next;
    logic              clock_new_reg;
    logic              clock_new_next;
    alarm_entry_t      alarm_table_reg [ALARM_SLOTS];
    logic              alarm_changed_reg;
    logic              alarm_changed_next;
    logic [SLOT_W-1:0] last_slot_reg;
    logic [SLOT_W-1:0] last_slot_next;
    logic              alarm_ever_reg;
    logic              alarm_ever_next;

    logic              is_byte;
    logic [31:0]       tick_gap;
    logic              gap_hit;
    logic              frame_done;
    logic [7:0]        slot_off;
    logic [SLOT_W-1:0] slot_idx;
    logic              alarm_hit;
    logic              time_hit;
    alarm_entry_t      new_entry;
    alarm_entry_t      shown_entry;
    logic [SLOT_W-1:0] shown_slot;
    logic [7:0]        slot_wide;

    assign is_byte  = item_valid && (item.func == FUNC_BYTE);
    assign tick_gap = item.now_tick - last_tick_reg;
    assign gap_hit  = tick_gap > {16'd0, timeout_reg};
    assign stage_eff = (gap_hit && stage_reg != STG_IDLE) ? STG_IDLE : stage_reg;

    // next state of the framing
    always_comb begin
        stage_next = stage_reg;
        if (is_byte) begin
            case (stage_eff)
                STG_IDLE: stage_next = STG_ONE;
                STG_ONE:  stage_next = STG_TWO;
                default:  stage_next = STG_IDLE;
            endcase
        end
    end

    // frame decode
    assign frame_done = is_byte && (stage_eff == STG_TWO);
    assign slot_off   = byte_one_reg - ALARM_BASE;
    assign slot_idx   = slot_off[SLOT_W-1:0];
    assign alarm_hit  = frame_done && (byte_one_reg >= ALARM_BASE)
                        && (slot_off < 8'(ALARM_SLOTS))
                        && (byte_two_reg <= HOUR_MAX) && (item.rx_byte <= MINSEC_MAX);
    assign time_hit   = frame_done && (byte_one_reg < ALARM_BASE)
                        && (byte_two_reg <= MINSEC_MAX) && (item.rx_byte <= MINSEC_MAX)
                        && !(byte_one_reg == CHAR_CR && byte_two_reg == CHAR_LF);

    assign new_entry.enabled = 1'b1;
    assign new_entry.hour    = byte_two_reg[4:0];
    assign new_entry.minute  = item.rx_byte[5:0];

    always_comb begin
        byte_one_next      = byte_one_reg;
        byte_two_next      = byte_two_reg;
        last_tick_next     = last_tick_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        clock_valid_next   = clock_valid_reg;
        clock_new_next     = clock_new_reg;
        alarm_changed_next = alarm_changed_reg;
        last_slot_next     = last_slot_reg;
        alarm_ever_next    = alarm_ever_reg;
        if (item_valid) begin
            case (item.func)
                FUNC_BYTE: begin
                    last_tick_next = item.now_tick;
                    if (stage_eff == STG_IDLE) begin
                        byte_one_next = item.rx_byte;
                    end
                    if (stage_eff == STG_ONE) begin
                        byte_two_next = item.rx_byte;
                    end
                    if (time_hit) begin
                        hour_next        = byte_one_reg[4:0];
                        minute_next      = byte_two_reg[5:0];
                        second_next      = item.rx_byte[5:0];
                        clock_valid_next = 1'b1;
                        clock_new_next   = 1'b1;
                    end
                    if (alarm_hit) begin
                        alarm_changed_next = 1'b1;
                        last_slot_next     = slot_idx;
                        alarm_ever_next    = 1'b1;
                    end
                end
                FUNC_ACK_TIME: begin
                    if (clock_valid_reg) begin
                        clock_new_next = 1'b0;
                    end
                end
                FUNC_ACK_ALARM: begin
                    alarm_changed_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // result of this item
    assign shown_entry = alarm_hit ? new_entry : alarm_table_reg[last_slot_reg];
    assign shown_slot  = alarm_hit ? slot_idx : last_slot_reg;
    assign slot_wide   = 8'(shown_slot);

    always_comb begin
        result.frame_done      = frame_done;
        result.time_hour       = hour_next;
        result.time_minute     = minute_next;
        result.time_second     = second_next;
        result.time_valid      = clock_valid_next;
        result.time_new        = (item.func == FUNC_BYTE) ? clock_new_next : clock_new_reg;
        result.alarm_new       = (item.func == FUNC_BYTE) ? alarm_changed_next
                                                          : alarm_changed_reg;
        result.alarm_slot      = alarm_ever_next ? slot_wide[1:0] : 2'd0;
        result.alarm_hour      = alarm_ever_next ? shown_entry.hour : 5'd0;
        result.alarm_minute    = alarm_ever_next ? shown_entry.minute : 6'd0;
        result.alarm_enabled   = alarm_ever_next ? shown_entry.enabled : 1'b0;
        result.persist_request = alarm_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg       <= GAP_TIMEOUT_RESET;
            stage_reg         <= STG_IDLE;
            byte_one_reg      <= 8'd0;
            byte_two_reg      <= 8'd0;
            last_tick_reg     <= 32'd0;
            hour_reg          <= 5'd0;
            minute_reg        <= 6'd0;
            second_reg        <= 6'd0;
            clock_valid_reg   <= 1'b0;
            clock_new_reg     <= 1'b0;
            alarm_changed_reg <= 1'b0;
            last_slot_reg     <= '0;
            alarm_ever_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                timeout_reg <= cfg_data;
            end
            stage_reg         <= stage_next;
            byte_one_reg      <= byte_one_next;
            byte_two_reg      <= byte_two_next;
            last_tick_reg     <= last_tick_next;
            hour_reg          <= hour_next;
            minute_reg        <= minute_next;
            second_reg        <= second_next;
            clock_valid_reg   <= clock_valid_next;
            clock_new_reg     <= clock_new_next;
            alarm_changed_reg <= alarm_changed_next;
            last_slot_reg     <= last_slot_next;
            alarm_ever_reg    <= alarm_ever_next;
        end
    end

    // alarm table, defaults are midnight and enabled
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            if (!aresetn) begin
                alarm_table_reg[i] <= '{enabled: 1'b1, hour: 5'd0, minute: 6'd0};
            end else if (item_valid && alarm_hit && slot_idx == SLOT_W'(i)) begin
                alarm_table_reg[i] <= new_entry;
            end
        end
    end

endmodule

// ===== rtl/core/tbta_out_stage.sv =====
module tbta_out_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  tbta_pkg::result_t                    result,
    output logic                                 ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tbta_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import tbta_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign ready    = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.frame_done;
    assign m_tdata  = {5'd0,
                       res_reg.persist_request,
                       res_reg.alarm_enabled,
                       res_reg.alarm_minute,
                       res_reg.alarm_hour,
                       res_reg.alarm_slot,
                       res_reg.alarm_new,
                       res_reg.time_new,
                       res_reg.time_valid,
                       res_reg.time_second,
                       res_reg.time_minute,
                       res_reg.time_hour};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

endmodule

// ===== rtl/core/three_byte_time_alarm_command_parser.sv =====
// an item passes the input register and then the result register before its result
// shows on m_tvalid; a stalled result register holds the item in the input register
// throughput: one item per cycle while the result register is not stalled, set by the
// state update between the input register and the result register
// reset: synchronous active-low aresetn empties both registers, clears framing and
// clock status, restores the alarm table defaults and a gap timeout of 500 ticks
module three_byte_time_alarm_command_parser #(
    parameter int ALARM_SLOTS = tbta_pkg::ALARM_SLOTS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // rx_byte [7:0], now_tick [39:8]
    input  logic [tbta_pkg::IN_TDATA_W-1:0]      s_tdata,
    // func [1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // time_hour [4:0], time_minute [10:5], time_second [16:11], time_valid [17],
    // time_new [18], alarm_new [19], alarm_slot [21:20], alarm_hour [26:22],
    // alarm_minute [32:27], alarm_enabled [33], persist_request [34]
    output logic [tbta_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // frame_done
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tbta_pkg::CFG_W-1:0]           cfg_data
);
    import tbta_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    out_ready;
    logic    advance;
    result_t result;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && out_ready;

    tbta_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tbta_core #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (advance),
        .item       (item),
        .result     (result)
    );

    tbta_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/tbta_checker.sv =====
module tbta_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tbta_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tlast
);
    import tbta_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a persist request comes only with a completed frame that set alarm-new
    a_persist_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tlast && m_tdata[19])
        else $error("persist request without alarm frame");

    a_time_new_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[17])
        else $error("time new without time valid");

    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:0] <= 5'd23 && m_tdata[26:22] <= 5'd23)
        else $error("hour out of range");

endmodule

bind three_byte_time_alarm_command_parser tbta_checker u_tbta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
